>>> rtl/spwm_pkg.sv
// Shared constants for the three-phase sine PWM block: register map, resets, sine math.
package spwm_pkg;

	// configuration port
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 17;

	localparam logic [REG_IDX_W-1:0] REG_DRIVE_MODE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_POWER_LEVEL = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_UV_TRIP     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_UV_RELEASE  = 3'd5;

	// drive modes
	localparam logic MODE_OFF    = 1'b0;
	localparam logic MODE_MANUAL = 1'b1;

	// register reset values
	localparam logic [15:0] PERIOD_RST     = 16'd4096;
	localparam logic [11:0] UV_TRIP_RST    = 12'd1307;
	localparam logic [11:0] UV_RELEASE_RST = 12'd1436;

	// phase and amplitude scale
	localparam logic [15:0] THIRD_TURN = 16'd21845;
	localparam logic [16:0] FULL_POWER = 17'd65536;

	// quarter-wave sine series in Q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1073741824;
	localparam int              TAYLOR_N    = 6;
	localparam longint unsigned TAYLOR_DIV [TAYLOR_N] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
	};

endpackage

>>> rtl/three_phase_sine_pwm_with_uv_lockout_unit.sv
// Three-phase sine PWM compare generator with supply undervoltage lockout.
//
//  channel | signals                                      | direction | handshake
//  --------+----------------------------------------------+-----------+----------------
//  in      | supply_sample                                | in        | in_valid/in_ready
//  out     | duty_a, duty_b, duty_c, drive_enabled,       | out       | out_valid/out_ready
//          | phase_now                                    |           |
//  config  | wr_index, wr_data                            | in        | wr_en, no wait
//
// A driving item steps through the sequencer in order: a sine ROM read step and a
// scale multiply step for each of the three phases, then divide steps in which the
// period is scanned one bit per cycle through three serial multiply-divide lanes,
// then the clamp step into the output register. An item that does not drive
// (undervoltage or off mode) goes from acceptance straight to the clamp step. A
// stalled output holds the sequencer in its clamp step until the output register is
// free; in_ready is high only in idle, so a new item waits for the clamp step. Reset
// clears the sequencer, state and output valid; registers return to their reset values.
module three_phase_sine_pwm_with_uv_lockout_unit #(
	parameter int SINE_ENTRIES = 1024,
	parameter int SINE_BITS    = 16,
	parameter int GUARD_TICKS  = 150
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           wr_en,
	input  logic [spwm_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [spwm_pkg::CFG_W-1:0]     wr_data,
	// input items
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [11:0]                    supply_sample,
	// result items
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [15:0]                    duty_a,
	output logic [15:0]                    duty_b,
	output logic [15:0]                    duty_c,
	output logic                           drive_enabled,
	output logic [15:0]                    phase_now
);
	import spwm_pkg::*;

	localparam int IDX_W = $clog2(SINE_ENTRIES);
	localparam int NW    = SINE_BITS + 16;          // holds 0 .. 2*span
	localparam int RW    = NW + 2;                  // doubled remainder plus addend
	localparam int MW    = SINE_BITS + 18;          // signed sine times power
	localparam longint unsigned AMP  = (64'd1 << (SINE_BITS - 1)) - 64'd1;
	localparam longint unsigned SPAN = AMP * 64'd65536;
	localparam logic [RW-1:0] DEN    = RW'(2 * SPAN);
	localparam logic [RW-1:0] DEN2   = RW'(4 * SPAN);
	localparam logic [MW-1:0] SPAN_M = MW'(SPAN);
	localparam logic [15:0]   GUARD  = 16'(GUARD_TICKS);

	// sequencer codes
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_MULT  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_CLAMP = 3'd4;

	// one ROM entry, quarter-wave series folded to the full turn
	function automatic logic signed [SINE_BITS-1:0] sine_at(input int k);
		longint unsigned four_k, quad, rem, u, x, x2, term, pos, neg, r, mag;
		longint signed   sv;
		int              n;
		four_k = 64'(4 * k);
		quad   = four_k / SINE_ENTRIES;
		rem    = four_k % SINE_ENTRIES;
		u      = quad[0] ? (64'(SINE_ENTRIES) - rem) : rem;
		x      = (HALF_PI_Q30 * u) / SINE_ENTRIES;
		x2     = (x * x) >> 30;
		term   = x;
		pos    = x;
		neg    = 64'd0;
		for (n = 0; n < TAYLOR_N; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if ((n % 2) == 0) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		r   = (pos > neg) ? (pos - neg) : 64'd0;
		r   = (r > ONE_Q30) ? ONE_Q30 : r;
		mag = (r * AMP + (ONE_Q30 >> 1)) >> 30;
		sv  = (quad >= 64'd2) ? -longint'(mag) : longint'(mag);
		return SINE_BITS'(sv);
	endfunction

	// ROM index of a phase: (p * entries) >> 16
	function automatic logic [IDX_W-1:0] phase_index(input logic [15:0] p);
		logic [16+IDX_W-1:0] prod;
		prod = (16 + IDX_W)'(p) * (16 + IDX_W)'(SINE_ENTRIES);
		return prod[16+IDX_W-1:16];
	endfunction

	// guard-band clamp
	function automatic logic [15:0] clamp_duty(input logic [15:0] d, input logic [15:0] hi);
		logic [15:0] res;
		if (d < GUARD) begin
			res = GUARD;
		end else if (d > hi) begin
			res = hi;
		end else begin
			res = d;
		end
		return res;
	endfunction

	// sine ROM
	logic signed [SINE_BITS-1:0] rom_tab [SINE_ENTRIES];
	for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
		assign rom_tab[k] = sine_at(k);
	end

	// configuration registers
	logic        drive_mode_q;
	logic [16:0] power_level_q;
	logic [15:0] phase_step_q;
	logic [15:0] period_q;
	logic [11:0] uv_trip_q;
	logic [11:0] uv_release_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_mode_q  <= MODE_OFF;
			power_level_q <= '0;
			phase_step_q  <= '0;
			period_q      <= PERIOD_RST;
			uv_trip_q     <= UV_TRIP_RST;
			uv_release_q  <= UV_RELEASE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_DRIVE_MODE:  drive_mode_q  <= wr_data[0];
				REG_POWER_LEVEL: power_level_q <= wr_data[16:0];
				REG_PHASE_STEP:  phase_step_q  <= wr_data[15:0];
				REG_PERIOD:      period_q      <= wr_data[15:0];
				REG_UV_TRIP:     uv_trip_q     <= wr_data[11:0];
				REG_UV_RELEASE:  uv_release_q  <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	// sequencer and datapath registers
	logic [2:0]                  state_q;
	logic [1:0]                  lane_q;
	logic [3:0]                  bit_q;
	logic                        ok_q;
	logic                        run_q;
	logic [15:0]                 phase_q;
	logic [16:0]                 pw_q;
	logic [15:0]                 per_sh_q;
	logic signed [SINE_BITS-1:0] rom_q;
	logic [NW-1:0]               n_q   [3];
	logic [NW-1:0]               rem_q [3];
	logic [15:0]                 quo_q [3];

	logic                        out_valid_q;
	logic [15:0]                 duty_a_q, duty_b_q, duty_c_q, phase_now_q;
	logic                        drive_en_q;

	// hysteresis and phase update for the incoming item
	logic        accept;
	logic        ok_next;
	logic        run_next;
	logic [15:0] phase_next;

	assign accept = in_valid && in_ready;

	always_comb begin
		if (ok_q) begin
			ok_next = !(supply_sample < uv_trip_q);
		end else begin
			ok_next = (supply_sample > uv_release_q);
		end
		run_next   = ok_next && (drive_mode_q == MODE_MANUAL);
		phase_next = phase_q;
		if (ok_next) begin
			phase_next = (drive_mode_q == MODE_MANUAL) ? (phase_q + phase_step_q) : 16'd0;
		end
	end

	// ROM address of the current lane
	logic [15:0]      lane_phase;
	logic [IDX_W-1:0] rom_addr;

	always_comb begin
		case (lane_q)
			2'd1:    lane_phase = phase_q - THIRD_TURN;
			2'd2:    lane_phase = phase_q + THIRD_TURN;
			default: lane_phase = phase_q;
		endcase
		rom_addr = phase_index(lane_phase);
	end

	// scaled sine plus offset: span + s * power
	logic signed [MW-1:0] prod_m;
	logic [MW-1:0]        n_sum;

	assign prod_m = MW'(rom_q) * MW'(signed'({1'b0, pw_q}));
	assign n_sum  = SPAN_M + prod_m;

	// serial multiply-divide lanes: q = floor(n * period / den), period MSB first
	logic [NW-1:0] rem_nx [3];
	logic [15:0]   quo_nx [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic [RW-1:0] r2;
		logic [1:0]    dig;
		always_comb begin
			r2 = {1'b0, rem_q[i], 1'b0} + (per_sh_q[15] ? {2'b00, n_q[i]} : '0);
			if (r2 >= DEN2) begin
				dig = 2'd2;
				r2  = r2 - DEN2;
			end else if (r2 >= DEN) begin
				dig = 2'd1;
				r2  = r2 - DEN;
			end else begin
				dig = 2'd0;
			end
			rem_nx[i] = r2[NW-1:0];
			quo_nx[i] = {quo_q[i][14:0], 1'b0} + 16'(dig);
		end
	end

	// upper clamp, saturated at zero
	logic [15:0] hi_lim;
	assign hi_lim = (period_q >= GUARD) ? (period_q - GUARD) : 16'd0;

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lane_q  <= '0;
			bit_q   <= '0;
			ok_q    <= 1'b0;
			run_q   <= 1'b0;
			phase_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ok_q    <= ok_next;
						run_q   <= run_next;
						phase_q <= phase_next;
						lane_q  <= '0;
						state_q <= run_next ? S_READ : S_CLAMP;
					end
				end
				S_READ: begin
					state_q <= S_MULT;
				end
				S_MULT: begin
					if (lane_q == 2'd2) begin
						bit_q   <= '0;
						state_q <= S_DIV;
					end else begin
						lane_q  <= lane_q + 2'd1;
						state_q <= S_READ;
					end
				end
				S_DIV: begin
					bit_q <= bit_q + 4'd1;
					if (bit_q == 4'd15) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			pw_q     <= (power_level_q > FULL_POWER) ? FULL_POWER : power_level_q;
			per_sh_q <= period_q;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end
		end
		if (state_q == S_READ) begin
			rom_q <= rom_tab[rom_addr];
		end
		if (state_q == S_MULT) begin
			n_q[lane_q] <= n_sum[NW-1:0];
		end
		if (state_q == S_DIV) begin
			per_sh_q <= {per_sh_q[14:0], 1'b0};
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= rem_nx[i];
				quo_q[i] <= quo_nx[i];
			end
		end
	end

	// output register
	logic load_out;
	assign load_out = (state_q == S_CLAMP) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			duty_a_q    <= run_q ? clamp_duty(quo_q[0], hi_lim) : 16'd0;
			duty_b_q    <= run_q ? clamp_duty(quo_q[1], hi_lim) : 16'd0;
			duty_c_q    <= run_q ? clamp_duty(quo_q[2], hi_lim) : 16'd0;
			drive_en_q  <= ok_q;
			phase_now_q <= phase_q;
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign duty_a        = duty_a_q;
	assign duty_b        = duty_b_q;
	assign duty_c        = duty_c_q;
	assign drive_enabled = drive_en_q;
	assign phase_now     = phase_now_q;

	// checks
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after taking an item");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> (RW'(rem_q[0]) < DEN) && (RW'(rem_q[1]) < DEN)
			&& (RW'(rem_q[2]) < DEN))
		else $error("divider remainder out of range");

	a_uv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_enabled |-> duty_a == 16'd0 && duty_b == 16'd0 && duty_c == 16'd0)
		else $error("nonzero duty while drive is locked out");

	a_uv_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !ok_next |=> phase_q == $past(phase_q))
		else $error("phase moved during undervoltage");

endmodule
